// ===== design/mcr_pkg.sv =====
// Shared types, constants and register codes for the midpoint circle rasterizer.
`default_nettype none
package mcr_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 200;

  localparam int ADDR_W  = 20;
  localparam int COLOR_W = 5;
  localparam int DEC_W   = 11;
  localparam int CX_W    = 9;
  localparam int CY_W    = 8;
  localparam int OFS_W   = 8;
  // coordinates after adding or subtracting an offset, two's complement
  localparam int COORD_W = 12;

  // register indexes on the configuration port
  localparam logic [2:0] REG_FRAME_BASE  = 3'd0;
  localparam logic [2:0] REG_CENTER_X    = 3'd1;
  localparam logic [2:0] REG_CENTER_Y    = 3'd2;
  localparam logic [2:0] REG_RADIUS      = 3'd3;
  localparam logic [2:0] REG_START_COLOR = 3'd4;

  localparam logic [ADDR_W-1:0]  FRAME_BASE_RST  = 20'hA0000;
  localparam logic [CX_W-1:0]    CENTER_X_RST    = 9'd160;
  localparam logic [CY_W-1:0]    CENTER_Y_RST    = 8'd100;
  localparam logic [OFS_W-1:0]   RADIUS_RST      = 8'd50;
  localparam logic [COLOR_W-1:0] START_COLOR_RST = 5'd15;

  typedef struct packed {
    logic [ADDR_W-1:0]  frame_base;
    logic [CX_W-1:0]    center_x;
    logic [CY_W-1:0]    center_y;
    logic [OFS_W-1:0]   radius;
    logic [COLOR_W-1:0] start_color;
  } cfg_t;

  // one classified step handed from front to back
  typedef struct packed {
    logic               done;
    logic [OFS_W-1:0]   x;
    logic [OFS_W-1:0]   y;
    logic [COLOR_W-1:0] color;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

// ===== design/mcr_front.sv =====
// Step front end: holds the circle state, classifies each step and issues a job.
`default_nettype none
module mcr_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mcr_pkg::cfg_t cfg,
  input  wire logic          accept,
  input  wire logic          restart,
  output mcr_pkg::job_t      job
);
  import mcr_pkg::*;

  logic [OFS_W-1:0]   x_r, x_nxt;
  logic [OFS_W-1:0]   y_r, y_nxt;
  logic [DEC_W-1:0]   dec_r, dec_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;

  logic [OFS_W-1:0]   xs, ys;
  logic [DEC_W-1:0]   ds;
  logic [COLOR_W-1:0] cs, cn;
  logic               fin;
  logic [DEC_W-1:0]   x_ext, y_ext;

  always_comb begin
    if (restart) begin
      xs = '0;
      ys = cfg.radius;
      ds = DEC_W'(1) - DEC_W'(cfg.radius);
      cs = cfg.start_color;
    end else begin
      xs = x_r;
      ys = y_r;
      ds = dec_r;
      cs = color_r;
    end
    fin   = (xs >= ys);
    cn    = {1'b0, cs[3:0]} + COLOR_W'(1);
    x_ext = DEC_W'(xs);
    y_ext = DEC_W'(ys);

    x_nxt     = xs;
    y_nxt     = ys;
    dec_nxt   = ds;
    color_nxt = cs;
    if (!fin) begin
      color_nxt = cn;
      x_nxt     = xs + OFS_W'(1);
      if (ds[DEC_W-1]) begin
        dec_nxt = ds + (x_ext << 1) + DEC_W'(3);
      end else begin
        dec_nxt = ds + ((x_ext - y_ext) << 1) + DEC_W'(5);
        y_nxt   = ys - OFS_W'(1);
      end
    end

    job.done  = fin;
    job.x     = xs;
    job.y     = ys;
    job.color = cn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r     <= '0;
      y_r     <= RADIUS_RST;
      dec_r   <= DEC_W'(1) - DEC_W'(RADIUS_RST);
      color_r <= START_COLOR_RST;
    end else if (accept) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      dec_r   <= dec_nxt;
      color_r <= color_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/mcr_queue.sv =====
// Two-entry job queue between the front end and the pixel back end.
`default_nettype none
module mcr_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire mcr_pkg::job_t push_data,
  input  wire logic          pop,
  output mcr_pkg::job_t      pop_data,
  output mcr_pkg::q_status_t status
);
  import mcr_pkg::*;

  job_t       entries_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign pop_data     = entries_r[rd_ptr_r];
  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

// ===== design/mcr_back.sv =====
// Back end: walks a job's eight symmetric points, or one done result, into the output.
`default_nettype none
module mcr_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire mcr_pkg::cfg_t                cfg,
  input  wire logic                         q_valid,
  input  wire mcr_pkg::job_t                q_data,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [mcr_pkg::ADDR_W-1:0]        out_pixel_addr,
  output logic [mcr_pkg::COLOR_W-1:0]       out_pixel_color,
  output logic                              out_off_screen,
  output logic                              out_last,
  output logic                              out_done_res
);
  import mcr_pkg::*;

  localparam logic signed [COORD_W-1:0] WIDTH_S  = COORD_W'(SCREEN_WIDTH);
  localparam logic signed [COORD_W-1:0] HEIGHT_S = COORD_W'(SCREEN_HEIGHT);

  job_t       cur_r;
  logic       busy_r;
  logic [2:0] pt_r;

  logic                      load_ok, adv, last_pt;
  logic [COORD_W-1:0]        cx_e, cy_e, a_e, b_e;
  logic signed [COORD_W-1:0] px, py;
  logic [ADDR_W-1:0]         py_ext, row_off, addr;
  logic                      off;

  assign load_ok = !out_valid || !out_stall;
  assign adv     = busy_r && load_ok;
  assign last_pt = cur_r.done || (pt_r == 3'd7);
  assign q_pop   = q_valid && (!busy_r || (adv && last_pt));

  // points 0-3 use (x,y), points 4-7 swap them; bit 1 negates px, bit 0 negates py
  always_comb begin
    cx_e = COORD_W'(cfg.center_x);
    cy_e = COORD_W'(cfg.center_y);
    a_e  = pt_r[2] ? COORD_W'(cur_r.y) : COORD_W'(cur_r.x);
    b_e  = pt_r[2] ? COORD_W'(cur_r.x) : COORD_W'(cur_r.y);
    px   = pt_r[1] ? cx_e - a_e : cx_e + a_e;
    py   = pt_r[0] ? cy_e - b_e : cy_e + b_e;
    py_ext  = {{(ADDR_W-COORD_W){py[COORD_W-1]}}, py};
    row_off = ADDR_W'(py_ext * ADDR_W'(SCREEN_WIDTH));
    addr    = cfg.frame_base + {{(ADDR_W-COORD_W){px[COORD_W-1]}}, px} + row_off;
    off     = (px < 0) || (px >= WIDTH_S) || (py < 0) || (py >= HEIGHT_S);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      pt_r      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        pt_r   <= '0;
      end else if (adv && last_pt) begin
        busy_r <= 1'b0;
      end else if (adv) begin
        pt_r <= pt_r + 3'd1;
      end
      if (load_ok) out_valid <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_data;
    if (adv) begin
      if (cur_r.done) begin
        out_pixel_addr  <= '0;
        out_pixel_color <= '0;
        out_off_screen  <= 1'b0;
        out_last        <= 1'b1;
        out_done_res    <= 1'b1;
      end else begin
        out_pixel_addr  <= addr;
        out_pixel_color <= cur_r.color;
        out_off_screen  <= off;
        out_last        <= (pt_r == 3'd7);
        out_done_res    <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/midpoint_circle_rasterizer.sv =====
// Top level of the midpoint circle rasterizer: config registers, front end, queue, back end.
//
//   channel | direction | handshake                  | payload
//   in      | input     | in_valid / in_stall        | in_restart
//   out     | output    | out_valid / out_stall      | pixel_addr, pixel_color, off_screen,
//           |           |                            | last, done_res
//   cfg     | input     | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// A step is classified combinationally in the front end and is queued (two entries).
// Unless out_stall holds it, the back end drives one result per cycle: eight for a drawing
// step, one when done, so a drawing step occupies the single output port for eight results.
// Synchronous active-low reset restores the circle state and register defaults.
// in_stall rises only while the job queue is full; out_stall holds the output register.
`default_nettype none
module midpoint_circle_rasterizer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_restart,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [mcr_pkg::ADDR_W-1:0]          out_pixel_addr,
  output logic [mcr_pkg::COLOR_W-1:0]         out_pixel_color,
  output logic                                out_off_screen,
  output logic                                out_last,
  output logic                                out_done_res,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [4:0]                     paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import mcr_pkg::*;

  cfg_t      cfg_r;
  job_t      front_job, q_data;
  q_status_t q_stat;
  logic      in_accept, q_pop, wr_en;
  logic [2:0] reg_idx;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[4:2];
  assign in_stall  = q_stat.full;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_base  <= FRAME_BASE_RST;
      cfg_r.center_x    <= CENTER_X_RST;
      cfg_r.center_y    <= CENTER_Y_RST;
      cfg_r.radius      <= RADIUS_RST;
      cfg_r.start_color <= START_COLOR_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME_BASE:  cfg_r.frame_base  <= pwdata[ADDR_W-1:0];
        REG_CENTER_X:    cfg_r.center_x    <= pwdata[CX_W-1:0];
        REG_CENTER_Y:    cfg_r.center_y    <= pwdata[CY_W-1:0];
        REG_RADIUS:      cfg_r.radius      <= pwdata[OFS_W-1:0];
        REG_START_COLOR: cfg_r.start_color <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_BASE:  prdata = 32'(cfg_r.frame_base);
      REG_CENTER_X:    prdata = 32'(cfg_r.center_x);
      REG_CENTER_Y:    prdata = 32'(cfg_r.center_y);
      REG_RADIUS:      prdata = 32'(cfg_r.radius);
      REG_START_COLOR: prdata = 32'(cfg_r.start_color);
      default:         prdata = '0;
    endcase
  end

  mcr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .accept  (in_accept),
    .restart (in_restart),
    .job     (front_job)
  );

  mcr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (front_job),
    .pop       (q_pop),
    .pop_data  (q_data),
    .status    (q_stat)
  );

  mcr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (!q_stat.empty),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_addr  (out_pixel_addr),
    .out_pixel_color (out_pixel_color),
    .out_off_screen  (out_off_screen),
    .out_last        (out_last),
    .out_done_res    (out_done_res)
  );

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_last && !out_off_screen)
    else $error("done result without last");

  a_pixel_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_pixel_color != 5'd0 && out_pixel_color <= 5'd16)
    else $error("pixel color out of range");

  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire
